### hdl/ec2p_pkg.sv
// Package with types and constants shared by the conserved-to-primitive pipeline.
`default_nettype none
package ec2p_pkg;

  localparam int unsigned GW = 18;  // gamma register width

  localparam logic [GW-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [GW-1:0] GAMMA_ONE = 18'd65536;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DENSITY = 2'd1;
  localparam logic [1:0] ST_PRESSURE = 2'd2;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // Sideband carried through the kinetic energy divider.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] en;
  } ke_side_t;

  // Sideband carried through the x velocity divider.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] my;
    logic signed [31:0] en;
    logic               mx_neg;
    logic [63:0]        ke;
  } u_side_t;

  // Sideband carried through the y velocity divider.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] en;
    logic [63:0]        ke;
    logic signed [31:0] u;
    logic               my_neg;
  } v_side_t;

  // Sideband carried through the temperature divider.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] p;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic [63:0]        ssum;
  } t_side_t;

  // Sideband carried through the speed square root.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] p;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] t;
  } spd_side_t;

  // Finished fields carried through the sound speed path.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] p;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] t;
    logic [30:0]        speed;
  } res_side_t;

  // Sideband carried through the Mach divider.
  typedef struct packed {
    res_side_t res;
    logic      c_zero;
  } mach_side_t;

endpackage
`default_nettype wire

### hdl/euler_conserved_to_primitive.sv
// Throughput: one item per cycle; the whole pipeline advances together whenever the
//   output register is empty or its item is being taken, so out_tready stalls everything.
// Depth is set by the chain of divider and root stages (64+48+48+48 divider bits,
//   32 root bits, 50 divider bits, 32 root bits, 47 divider bits) plus register stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets gamma to 1.4.
`default_nettype none
module euler_conserved_to_primitive (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: density, x_momentum, y_momentum, total_energy (32 bits each, lowest first)
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,
  // out_tdata: x_velocity[31:0], y_velocity[63:32], gas_pressure[95:64],
  //   gas_temperature[127:96], flow_speed[158:128], mach_number[189:159], status[191:190]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,
  // heat_capacity_ratio write, unsigned Q2.16
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [17:0]  cfg_data
);

  // ---------------------------------------------------------------- helpers
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    mag32 = a[31] ? 32'(-a) : 32'(a);
  endfunction

  // saturate a magnitude with sign to signed Q16.16
  function automatic logic signed [31:0] sat_mag(input logic [49:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (m >= 50'h8000_0000) ? 32'sh8000_0000 : 32'(-m[31:0]);
    end else begin
      r = (m >= 50'h8000_0000) ? 32'sh7FFF_FFFF : 32'(m[31:0]);
    end
    sat_mag = r;
  endfunction

  // ---------------------------------------------------------------- control
  logic adv;
  logic out_tvalid_r;
  logic [191:0] out_tdata_r;
  logic [17:0] gam_r;

  // advance every stage together unless the output register holds an untaken item
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gam_r <= ec2p_pkg::GAMMA_RESET;
    end else if (cfg_valid) begin
      gam_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- input stage
  logic s0_v_r;
  ec2p_pkg::ke_side_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.rho <= in_tdata[31:0];
      s0_r.mx  <= in_tdata[63:32];
      s0_r.my  <= in_tdata[95:64];
      s0_r.en  <= in_tdata[127:96];
    end
  end

  // ---------------------------------------------------------------- momentum squares
  logic s1_v_r;
  ec2p_pkg::ke_side_t s1_r;
  logic [63:0] mx2_r, my2_r;
  logic [31:0] mxm, mym;

  assign mxm = mag32(s0_r.mx);
  assign mym = mag32(s0_r.my);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s0_r;
      mx2_r <= 64'(mxm) * 64'(mxm);
      my2_r <= 64'(mym) * 64'(mym);
    end
  end

  // ---------------------------------------------------------------- momentum sum
  logic s2_v_r;
  ec2p_pkg::ke_side_t s2_r;
  logic [63:0] m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s1_r;
      m2_r <= mx2_r + my2_r;
    end
  end

  // ---------------------------------------------------------------- kinetic energy
  // ke = floor((mx^2+my^2) / (2*rho))
  logic ke_v;
  logic [63:0] ke_q;
  ec2p_pkg::ke_side_t ke_s;

  ec2p_div #(
    .NW(64),
    .DW(33),
    .SW($bits(ec2p_pkg::ke_side_t))
  ) u_div_ke (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s2_v_r),
    .num      (m2_r),
    .den      ({s2_r.rho, 1'b0}),
    .side_in  (s2_r),
    .out_valid(ke_v),
    .quo      (ke_q),
    .side_out (ke_s)
  );

  // ---------------------------------------------------------------- x velocity
  ec2p_pkg::u_side_t u_in, u_s;
  logic u_v;
  logic [47:0] u_q;

  always_comb begin
    u_in.rho    = ke_s.rho;
    u_in.my     = ke_s.my;
    u_in.en     = ke_s.en;
    u_in.mx_neg = ke_s.mx[31];
    u_in.ke     = ke_q;
  end

  ec2p_div #(
    .NW(48),
    .DW(32),
    .SW($bits(ec2p_pkg::u_side_t))
  ) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (ke_v),
    .num      ({mag32(ke_s.mx), 16'h0000}),
    .den      (ke_s.rho),
    .side_in  (u_in),
    .out_valid(u_v),
    .quo      (u_q),
    .side_out (u_s)
  );

  // ---------------------------------------------------------------- y velocity
  ec2p_pkg::v_side_t v_in, v_s;
  logic v_v;
  logic [47:0] v_q;

  always_comb begin
    v_in.rho    = u_s.rho;
    v_in.en     = u_s.en;
    v_in.ke     = u_s.ke;
    v_in.u      = sat_mag({2'b00, u_q}, u_s.mx_neg);
    v_in.my_neg = u_s.my[31];
  end

  ec2p_div #(
    .NW(48),
    .DW(32),
    .SW($bits(ec2p_pkg::v_side_t))
  ) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (u_v),
    .num      ({mag32(u_s.my), 16'h0000}),
    .den      (u_s.rho),
    .side_in  (v_in),
    .out_valid(v_v),
    .quo      (v_q),
    .side_out (v_s)
  );

  // ---------------------------------------------------------------- internal energy
  logic p1_v_r;
  logic signed [31:0] p1_rho_r, p1_u_r, p1_v_vel_r;
  logic [47:0] p1_ma_r;
  logic p1_neg_r;
  logic [64:0] eint;
  logic [64:0] eneg;
  logic [64:0] emag;

  assign eint = {{33{v_s.en[31]}}, v_s.en} - {1'b0, v_s.ke};
  // form both differences side by side; the magnitude is then a select
  assign eneg = {1'b0, v_s.ke} - {{33{v_s.en[31]}}, v_s.en};
  assign emag = eint[64] ? eneg : eint;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= v_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rho_r   <= v_s.rho;
      p1_u_r     <= v_s.u;
      p1_v_vel_r <= sat_mag({2'b00, v_q}, v_s.my_neg);
      // clamp to 2^47; larger values saturate the pressure anyway
      p1_ma_r    <= (emag > 65'h8000_0000_0000) ? 48'h8000_0000_0000 : emag[47:0];
      p1_neg_r   <= eint[64];
    end
  end

  // ---------------------------------------------------------------- (gamma-1) product
  logic p2_v_r;
  logic signed [31:0] p2_rho_r, p2_u_r, p2_v_vel_r;
  logic [65:0] p2_prod_r;
  logic p2_neg_r;
  logic [63:0] p2_usq_r, p2_vsq_r;
  logic g_neg;
  logic [17:0] g_mag;
  logic [31:0] um, vm;

  assign g_neg = (gam_r < ec2p_pkg::GAMMA_ONE);
  assign g_mag = g_neg ? 18'(ec2p_pkg::GAMMA_ONE - gam_r) : 18'(gam_r - ec2p_pkg::GAMMA_ONE);
  assign um    = mag32(p1_u_r);
  assign vm    = mag32(p1_v_vel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_rho_r   <= p1_rho_r;
      p2_u_r     <= p1_u_r;
      p2_v_vel_r <= p1_v_vel_r;
      p2_prod_r  <= 66'(p1_ma_r) * 66'(g_mag);
      p2_neg_r   <= p1_neg_r ^ g_neg;
      p2_usq_r   <= 64'(um) * 64'(um);
      p2_vsq_r   <= 64'(vm) * 64'(vm);
    end
  end

  // ---------------------------------------------------------------- pressure
  logic p3_v_r;
  ec2p_pkg::t_side_t p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (adv) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r.rho  <= p2_rho_r;
      p3_r.p    <= sat_mag(p2_prod_r[65:16], p2_neg_r);
      p3_r.u    <= p2_u_r;
      p3_r.v    <= p2_v_vel_r;
      p3_r.ssum <= p2_usq_r + p2_vsq_r;
    end
  end

  // ---------------------------------------------------------------- temperature
  logic t_v;
  logic [47:0] t_q;
  ec2p_pkg::t_side_t t_s;

  ec2p_div #(
    .NW(48),
    .DW(32),
    .SW($bits(ec2p_pkg::t_side_t))
  ) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (p3_v_r),
    .num      ({mag32(p3_r.p), 16'h0000}),
    .den      (p3_r.rho),
    .side_in  (p3_r),
    .out_valid(t_v),
    .quo      (t_q),
    .side_out (t_s)
  );

  // ---------------------------------------------------------------- flow speed
  ec2p_pkg::spd_side_t spd_in, spd_s;
  logic spd_v;
  logic [31:0] spd_root;

  always_comb begin
    spd_in.rho = t_s.rho;
    spd_in.p   = t_s.p;
    spd_in.u   = t_s.u;
    spd_in.v   = t_s.v;
    spd_in.t   = sat_mag({2'b00, t_q}, t_s.p[31]);
  end

  ec2p_sqrt #(
    .NW(64),
    .SW($bits(ec2p_pkg::spd_side_t))
  ) u_sqrt_spd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (t_v),
    .x        (t_s.ssum),
    .side_in  (spd_in),
    .out_valid(spd_v),
    .root     (spd_root),
    .side_out (spd_s)
  );

  // ---------------------------------------------------------------- gamma * p
  logic q1_v_r;
  ec2p_pkg::res_side_t q1_r;
  logic [49:0] q1_gp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
    end else if (adv) begin
      q1_v_r <= spd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r.rho   <= spd_s.rho;
      q1_r.p     <= spd_s.p;
      q1_r.u     <= spd_s.u;
      q1_r.v     <= spd_s.v;
      q1_r.t     <= spd_s.t;
      q1_r.speed <= spd_root[31] ? ec2p_pkg::MAX31 : spd_root[30:0];
      // only used when p is positive
      q1_gp_r    <= 50'(gam_r) * 50'(spd_s.p[30:0]);
    end
  end

  // ---------------------------------------------------------------- sound speed squared
  logic s2d_v;
  logic [49:0] s2d_q;
  ec2p_pkg::res_side_t s2d_s;
  logic [46:0] s2_clamp;

  ec2p_div #(
    .NW(50),
    .DW(32),
    .SW($bits(ec2p_pkg::res_side_t))
  ) u_div_s2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (q1_v_r),
    .num      (q1_gp_r),
    .den      (q1_r.rho),
    .side_in  (q1_r),
    .out_valid(s2d_v),
    .quo      (s2d_q),
    .side_out (s2d_s)
  );

  assign s2_clamp = (s2d_q[49:47] != 3'b000) ? {47{1'b1}} : s2d_q[46:0];

  // ---------------------------------------------------------------- sound speed
  logic c_v;
  logic [31:0] c_root;
  ec2p_pkg::res_side_t c_s;
  ec2p_pkg::mach_side_t m_in, m_s;

  ec2p_sqrt #(
    .NW(64),
    .SW($bits(ec2p_pkg::res_side_t))
  ) u_sqrt_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s2d_v),
    .x        ({1'b0, s2_clamp, 16'h0000}),
    .side_in  (s2d_s),
    .out_valid(c_v),
    .root     (c_root),
    .side_out (c_s)
  );

  always_comb begin
    m_in.res    = c_s;
    m_in.c_zero = (c_root == 32'd0);
  end

  // ---------------------------------------------------------------- Mach number
  logic m_v;
  logic [46:0] m_q;

  ec2p_div #(
    .NW(47),
    .DW(32),
    .SW($bits(ec2p_pkg::mach_side_t))
  ) u_div_m (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (c_v),
    .num      ({c_s.speed, 16'h0000}),
    .den      (c_root),
    .side_in  (m_in),
    .out_valid(m_v),
    .quo      (m_q),
    .side_out (m_s)
  );

  // ---------------------------------------------------------------- result assembly
  logic rho_pos, p_pos;
  logic [30:0] mach;
  logic [1:0] status;
  logic [191:0] res_data;

  assign rho_pos = !m_s.res.rho[31] && (m_s.res.rho != 32'sd0);
  assign p_pos   = !m_s.res.p[31] && (m_s.res.p != 32'sd0);

  always_comb begin
    if (m_s.c_zero || (m_q[46:31] != 16'h0000)) begin
      mach = ec2p_pkg::MAX31;
    end else begin
      mach = m_q[30:0];
    end
    if (!rho_pos) begin
      status   = ec2p_pkg::ST_DENSITY;
      res_data = {status, 190'd0};
    end else if (!p_pos) begin
      status   = ec2p_pkg::ST_PRESSURE;
      res_data = {status, 31'd0, m_s.res.speed, m_s.res.t, m_s.res.p, m_s.res.v, m_s.res.u};
    end else begin
      status   = ec2p_pkg::ST_OK;
      res_data = {status, mach, m_s.res.speed, m_s.res.t, m_s.res.p, m_s.res.v, m_s.res.u};
    end
  end

  // output register: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= res_data;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

### hdl/ec2p_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module ec2p_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      side_out
);

  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] nq_r   [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];
  logic          v_r    [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW-1:0] rem_c;
    logic [DW-1:0] den_c;
    logic [NW-1:0] nq_c;
    logic [SW-1:0] side_c;
    logic          v_c;
    logic [DW:0]   tmp;
    logic [DW:0]   diff;
    logic          take;

    if (g == 0) begin : g_head
      assign rem_c  = '0;
      assign den_c  = den;
      assign nq_c   = num;
      assign side_c = side_in;
      assign v_c    = in_valid;
    end else begin : g_body
      assign rem_c  = rem_r[g-1];
      assign den_c  = den_r[g-1];
      assign nq_c   = nq_r[g-1];
      assign side_c = side_r[g-1];
      assign v_c    = v_r[g-1];
    end

    // bring down the next numerator bit and try to subtract
    assign tmp  = {rem_c, nq_c[NW-1]};
    assign diff = tmp - {1'b0, den_c};
    assign take = (tmp >= {1'b0, den_c});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? diff[DW-1:0] : tmp[DW-1:0];
        nq_r[g]   <= {nq_c[NW-2:0], take};
        den_r[g]  <= den_c;
        side_r[g] <= side_c;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign quo       = nq_r[NW-1];
  assign side_out  = side_r[NW-1];

endmodule
`default_nettype wire

### hdl/ec2p_sqrt.sv
// Pipelined integer square root (floor), one root bit per stage.
`default_nettype none
module ec2p_sqrt #(
  parameter int unsigned NW = 64,
  parameter int unsigned SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   x,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [NW/2-1:0]      root,
  output logic [SW-1:0]        side_out
);

  localparam int unsigned RTW = NW / 2;
  localparam int unsigned RW = RTW + 2;

  logic [RW-1:0]  rem_r  [RTW];
  logic [RTW-1:0] root_r [RTW];
  logic [NW-1:0]  x_r    [RTW];
  logic [SW-1:0]  side_r [RTW];
  logic           v_r    [RTW];

  for (genvar g = 0; g < RTW; g++) begin : g_stage
    logic [RW-1:0]  rem_c;
    logic [RTW-1:0] root_c;
    logic [NW-1:0]  x_c;
    logic [SW-1:0]  side_c;
    logic           v_c;
    logic [RW+1:0]  tmp;
    logic [RW+1:0]  trial;
    logic [RW+1:0]  diff;
    logic           take;

    if (g == 0) begin : g_head
      assign rem_c  = '0;
      assign root_c = '0;
      assign x_c    = x;
      assign side_c = side_in;
      assign v_c    = in_valid;
    end else begin : g_body
      assign rem_c  = rem_r[g-1];
      assign root_c = root_r[g-1];
      assign x_c    = x_r[g-1];
      assign side_c = side_r[g-1];
      assign v_c    = v_r[g-1];
    end

    assign tmp   = {rem_c, x_c[NW-1:NW-2]};
    assign trial = {2'b00, root_c, 2'b01};
    assign diff  = tmp - trial;
    assign take  = (tmp >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? diff[RW-1:0] : tmp[RW-1:0];
        root_r[g] <= {root_c[RTW-2:0], take};
        x_r[g]    <= {x_c[NW-3:0], 2'b00};
        side_r[g] <= side_c;
      end
    end
  end

  assign out_valid = v_r[RTW-1];
  assign root      = root_r[RTW-1];
  assign side_out  = side_r[RTW-1];

endmodule
`default_nettype wire

### tb/euler_conserved_to_primitive_test.sv
// Self-checking regression for the conserved-to-primitive pipeline: directed and random points.
`default_nettype none
module euler_conserved_to_primitive_test;

  // One result item, packed in the order of out_tdata (last field lowest).
  typedef struct packed {
    logic [1:0]         status;
    logic [30:0]        mach;
    logic [30:0]        speed;
    logic signed [31:0] temp;
    logic signed [31:0] pres;
    logic signed [31:0] vy;
    logic signed [31:0] ux;
  } prim_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    logic signed [31:0] rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] en;
    bit                 typed;
    prim_t              want;
  } point_row_t;

  localparam int NUM_ROWS = 14;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam prim_t BAD_DENSITY = '{status: ec2p_pkg::ST_DENSITY, default: '0};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [17:0]  cfg_data = '0;

  logic [ec2p_pkg::GW-1:0] gamma_q = ec2p_pkg::GAMMA_RESET;  // predictor's copy of the register
  prim_t         prim_q[$];              // primitives still owed by the block
  int            errors = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  bit            send_burst = 1'b0;
  point_row_t    rows[NUM_ROWS];

  always #5 clk = ~clk;

  euler_conserved_to_primitive u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic longint sat32(longint v);
    if (v > longint'(SMAX)) return longint'(SMAX);
    if (v < longint'(SMIN)) return longint'(SMIN);
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Floor square root, one result bit per pass.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale internal energy by (gamma - 1), magnitude-wise, truncating toward zero.
  function automatic longint scale_q16(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned prod;
    ma = mag(a);
    mb = mag(b);
    if (ma > (64'd1 << 47)) ma = 64'd1 << 47;
    prod = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
    if (prod > (64'd1 << 40)) prod = 64'd1 << 40;
    return sat32(((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod));
  endfunction

  // Primitive variables of one point under the current gamma.
  function automatic prim_t primitives(logic signed [31:0] rho_i, logic signed [31:0] mx_i,
                                       logic signed [31:0] my_i, logic signed [31:0] en_i);
    prim_t r;
    longint rho, u, v, ke, p, t, gam;
    longint unsigned m2, speed, s2, c, mach;
    r = '0;
    rho = rho_i;
    gam = gamma_q;
    if (rho <= 0) begin
      r.status = ec2p_pkg::ST_DENSITY;
      return r;
    end
    u = sat32((longint'(mx_i) * 65536) / rho);
    v = sat32((longint'(my_i) * 65536) / rho);
    // kinetic energy straight from the raw momenta
    m2 = mag(mx_i) * mag(mx_i) + mag(my_i) * mag(my_i);
    ke = longint'(m2 / (longint'(2) * rho));
    p = scale_q16(longint'(en_i) - ke, gam - 65536);
    t = sat32((p * 65536) / rho);
    speed = floor_root(mag(u) * mag(u) + mag(v) * mag(v));
    if (speed > longint'(ec2p_pkg::MAX31)) speed = ec2p_pkg::MAX31;
    if (p <= 0) begin
      r.status = ec2p_pkg::ST_PRESSURE;
      mach = 0;
    end else begin
      s2 = (longint'(gam) * p) / rho;
      if (s2 > (64'd1 << 47) - 1) s2 = (64'd1 << 47) - 1;
      c = floor_root(s2 << 16);
      r.status = ec2p_pkg::ST_OK;
      if (c == 0) mach = ec2p_pkg::MAX31;
      else mach = (speed << 16) / c;
      if (mach > longint'(ec2p_pkg::MAX31)) mach = ec2p_pkg::MAX31;
    end
    r.ux = u[31:0];
    r.vy = v[31:0];
    r.pres = p[31:0];
    r.temp = t[31:0];
    r.speed = speed[30:0];
    r.mach = mach[30:0];
    return r;
  endfunction

  // Offer one point and hold it until taken; the gap before it is drawn here.
  task automatic send_point(logic signed [31:0] rho, logic signed [31:0] mx,
                            logic signed [31:0] my, logic signed [31:0] en,
                            prim_t want);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    prim_q = {prim_q, want};
    in_tvalid <= 1'b1;
    in_tdata <= {en, my, mx, rho};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every owed result is back, then write gamma.
  task automatic write_gamma(logic [ec2p_pkg::GW-1:0] g);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (prim_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gamma_q = g;
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom;
  endfunction

  // Mostly physical points: positive density, moderate momenta, energy that
  // usually leaves positive pressure; the rest is raw noise over all bits.
  task automatic send_random();
    logic signed [31:0] rho, mx, my, en;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      rho = $urandom_range(1, 32'h0040_0000) >> $urandom_range(0, 20);
      if (rho == 0) rho = 1;
      mx = rand_word() >>> $urandom_range(4, 31);
      my = rand_word() >>> $urandom_range(4, 31);
      en = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24);
      if (kind == 6) en = -en;
    end else begin
      rho = rand_word();
      mx = rand_word();
      my = rand_word();
      en = rand_word();
      if (kind == 9) rho = -(rho & SMAX);
    end
    send_point(rho, mx, my, en, primitives(rho, mx, my, en));
  endtask

  // Compare each result against the oldest owed one, field by field.
  always @(posedge clk) begin
    prim_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen <= results_seen + 1;
      if (prim_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = prim_q.pop_front();
        if (got.ux !== want.ux) begin
          $display("%0t: x_velocity exp %h got %h", $time, want.ux, got.ux);
          errors++;
        end
        if (got.vy !== want.vy) begin
          $display("%0t: y_velocity exp %h got %h", $time, want.vy, got.vy);
          errors++;
        end
        if (got.pres !== want.pres) begin
          $display("%0t: gas_pressure exp %h got %h", $time, want.pres, got.pres);
          errors++;
        end
        if (got.temp !== want.temp) begin
          $display("%0t: gas_temperature exp %h got %h", $time, want.temp, got.temp);
          errors++;
        end
        if (got.speed !== want.speed) begin
          $display("%0t: flow_speed exp %h got %h", $time, want.speed, got.speed);
          errors++;
        end
        if (got.mach !== want.mach) begin
          $display("%0t: mach_number exp %h got %h", $time, want.mach, got.mach);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  // Receiver: random hold-offs per item, bursts of full rate, and one long
  // stall after the first hundred results so the pipeline backs up to the input.
  initial begin
    int gap;
    bit rx_burst;
    bit held;
    rx_burst = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (1000) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Watchdog: count cycles with no handshake anywhere.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("euler_conserved_to_primitive regression: fail");
      $finish;
    end
  end

  initial begin
    logic [ec2p_pkg::GW-1:0] gammas[6];
    rows[0]  = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, BAD_DENSITY};
    rows[1]  = '{-32'sd1, SMAX, SMAX, SMAX, 1'b1, BAD_DENSITY};
    rows[2]  = '{SMIN, SMIN, SMIN, SMIN, 1'b1, BAD_DENSITY};
    // zero energy at rest: pressure exactly zero
    rows[3]  = '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                 '{status: ec2p_pkg::ST_PRESSURE, default: '0}};
    rows[4]  = '{32'sd65536, 32'sd0, 32'sd0, -32'sd65536, 1'b0, '0};
    rows[5]  = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1'b0, '0};
    rows[6]  = '{32'sd1, SMAX, SMAX, SMAX, 1'b0, '0};   // velocities saturate
    rows[7]  = '{32'sd1, SMIN, SMIN, SMIN, 1'b0, '0};   // huge internal energy
    rows[8]  = '{SMAX, SMAX, SMIN, SMAX, 1'b0, '0};
    rows[9]  = '{SMAX, 32'sd0, 32'sd0, 32'sd1, 1'b0, '0};
    rows[10] = '{SMAX, 32'sd0, 32'sd0, 32'sd40000, 1'b0, '0};  // zero sound speed
    rows[11] = '{32'sd65536, 32'sd32768, -32'sd16384, 32'sd196608, 1'b0, '0};
    rows[12] = '{32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, '0};
    rows[13] = '{32'sh2AAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, SMAX, 1'b0, '0};
    // reset default, range ends, below range (zero and 40000, about 0.61), all ones
    gammas = '{ec2p_pkg::GAMMA_RESET, ec2p_pkg::GAMMA_ONE, 18'd196608, 18'd0, 18'd40000,
               18'h3FFFF};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset value of gamma
    foreach (rows[i])
      send_point(rows[i].rho, rows[i].mx, rows[i].my, rows[i].en,
                 rows[i].typed ? rows[i].want
                               : primitives(rows[i].rho, rows[i].mx, rows[i].my, rows[i].en));

    // random phases, one per gamma setting, plus a random gamma at the end
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_gamma(ph < 6 ? gammas[ph] : 18'($urandom_range(65536, 196608)));
      for (int k = 0; k < 190; k++) begin
        if ($urandom_range(0, 47) == 0) send_burst = ~send_burst;
        send_random();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (prim_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("euler_conserved_to_primitive regression: pass");
    end else begin
      $display("euler_conserved_to_primitive regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
